@@ design/edk_pkg.sv @@
// shared types and constants of the eager-defer key debouncer
// no dependencies; imported by the interfaces and the top level
package edk_pkg;

   localparam int MAX_KEYS          = 32;
   localparam int KEY_IDX_W         = 5;
   localparam int PIN_BITS          = 16;
   localparam int PIN_IDX_W         = 4;
   localparam int TIME_W            = 32;
   localparam int KEY_COUNT_DEFAULT = 16;

   localparam logic [TIME_W-1:0] DEFAULT_SETTLE_US = 32'd7000;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_TIME   = 1'b1;
   localparam int CSR_DATA_W = 32;

   // debounce mode codes
   localparam logic MODE_PASS  = 1'b0;
   localparam logic MODE_EAGER = 1'b1;

   typedef struct packed {
      logic              pressed;
      logic              pending;
      logic [TIME_W-1:0] start_time;
   } key_state_type;

   localparam int KEY_STATE_W = $bits(key_state_type);

endpackage

@@ design/edk_req_if.sv @@
// scan request channel: raw pin levels and time stamp
// depends on edk_pkg
interface edk_req_if import edk_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIN_BITS-1:0] raw_levels;
   logic [TIME_W-1:0]   now_us;

   modport source (output valid, output raw_levels, output now_us, input ready);
   modport sink   (input valid, input raw_levels, input now_us, output ready);
endinterface

@@ design/edk_rsp_if.sv @@
// result channel: debounced pressed bitmap
// depends on edk_pkg
interface edk_rsp_if import edk_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIN_BITS-1:0] pressed_keys;

   modport source (output valid, output pressed_keys, input ready);
   modport sink   (input valid, input pressed_keys, output ready);
endinterface

@@ design/edk_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module edk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/eager_defer_key_debouncer.sv @@
// Per-key debouncer, eager press and deferred release.
// Depends on edk_pkg, edk_req_if, edk_rsp_if and edk_ram.
//
// Usage:
//   req_chan carries one scan: raw_levels (active-low pin per key) and now_us,
//   a free-running 32-bit microsecond time. rsp_chan returns one pressed_keys
//   bitmap for every scan, in order. csr_we/csr_index/csr_wdata write
//   debounce_mode (index 0) and settle_time_us (index 1) while idle.
//   Each key's pressed flag, pending flag and start time live in one ram
//   entry. A scan walks the keys one per cycle: read an entry, update it on
//   the returned data, write it back while the next key is read.
//   Keys are walked one at a time through the single read port of the key
//   state ram, and a new scan is accepted only when the block is back in idle,
//   after the bitmap of the previous scan has been loaded for output.
//   A new scan is taken while the previous bitmap still waits in the output
//   register; a stalled receiver holds the block at the end of the next scan
//   until the bitmap is taken.
//   Reset: mode eager-defer, settle time 7000 us, all keys released with no
//   pending interval (per-entry valid bits, no clearing pass).
module eager_defer_key_debouncer import edk_pkg::*; #(
   parameter int KEY_COUNT = KEY_COUNT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   edk_req_if.sink               req_chan,
   edk_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam logic [AW-1:0] LAST_KEY = AW'(KEY_COUNT - 1);
   localparam int LIVE_BITS = (KEY_COUNT < PIN_BITS) ? KEY_COUNT : PIN_BITS;
   localparam logic [PIN_BITS-1:0] LIVE_MASK =
      PIN_BITS'(((PIN_BITS + 1)'(1) << LIVE_BITS) - (PIN_BITS + 1)'(1));

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_type;

   state_type           state_ff;
   logic                mode_ff;
   logic [TIME_W-1:0]   settle_ff;
   logic [PIN_BITS-1:0] levels_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [AW-1:0]       rd_idx_ff;
   logic                rd_active_ff;
   logic [AW-1:0]       proc_idx_ff;
   logic                proc_valid_ff;
   logic                proc_live_ff;
   logic [KEY_COUNT-1:0] written_ff;
   logic [PIN_BITS-1:0] bitmap_ff;
   logic                rsp_valid_ff;
   logic [PIN_BITS-1:0] rsp_data_ff;

   logic                req_xfer;
   logic                rsp_xfer;
   logic [KEY_STATE_W-1:0] ram_rd_data;
   key_state_type       entry_cur;
   key_state_type       entry_in;
   logic [MAX_KEYS-1:0] pin_pressed;
   logic [KEY_IDX_W-1:0] key_sel;
   logic                lvl;
   logic [TIME_W-1:0]   elapsed;
   logic [PIN_BITS-1:0] bitmap_in;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.pressed_keys = rsp_data_ff;
   assign rsp_xfer       = rsp_valid_ff && rsp_chan.ready;

   edk_ram #(
      .WIDTH (KEY_STATE_W),
      .DEPTH (KEY_COUNT)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (proc_valid_ff),
      .wr_addr (proc_idx_ff),
      .wr_data (entry_in),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   // an entry never written reads as released, not pending, time zero
   always_comb begin
      if (proc_live_ff) begin
         entry_cur = key_state_type'(ram_rd_data);
      end else begin
         entry_cur = '0;
      end
   end

   assign pin_pressed = MAX_KEYS'(~levels_ff);
   assign key_sel     = KEY_IDX_W'(proc_idx_ff);
   assign lvl         = pin_pressed[key_sel];
   assign elapsed     = now_ff - entry_cur.start_time;

   always_comb begin
      entry_in = entry_cur;
      if (mode_ff == MODE_PASS) begin
         entry_in.pressed = lvl;
      end else if (lvl != entry_cur.pressed) begin
         if (!entry_cur.pending) begin
            entry_in.pending    = 1'b1;
            entry_in.start_time = now_ff;
            if (lvl) begin
               entry_in.pressed = 1'b1;
            end
         end else if (elapsed >= settle_ff) begin
            entry_in.pending = 1'b0;
            if (!lvl) begin
               entry_in.pressed = 1'b0;
            end
         end
      end else begin
         entry_in.pending = 1'b0;
      end
   end

   always_comb begin
      bitmap_in = bitmap_ff;
      if (req_xfer) begin
         bitmap_in = '0;
      end else if (proc_valid_ff && (key_sel < KEY_IDX_W'(PIN_BITS))) begin
         bitmap_in[key_sel[PIN_IDX_W-1:0]] = entry_in.pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mode_ff       <= MODE_EAGER;
         settle_ff     <= DEFAULT_SETTLE_US;
         rd_active_ff  <= 1'b0;
         proc_valid_ff <= 1'b0;
         written_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEBOUNCE_MODE: mode_ff   <= csr_wdata[0];
               CSR_SETTLE_TIME:   settle_ff <= TIME_W'(csr_wdata);
               default: ;
            endcase
         end

         // the finish state reloads the output register itself
         if (rsp_xfer && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         // read of key k+1 overlaps the write-back of key k
         proc_valid_ff <= rd_active_ff;
         proc_idx_ff   <= rd_idx_ff;
         proc_live_ff  <= written_ff[rd_idx_ff];
         if (rd_active_ff) begin
            rd_idx_ff <= rd_idx_ff + AW'(1);
            if (rd_idx_ff == LAST_KEY) begin
               rd_active_ff <= 1'b0;
            end
         end
         if (proc_valid_ff) begin
            written_ff[proc_idx_ff] <= 1'b1;
         end
         bitmap_ff <= bitmap_in;

         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  levels_ff    <= req_chan.raw_levels;
                  now_ff       <= req_chan.now_us;
                  rd_idx_ff    <= '0;
                  rd_active_ff <= 1'b1;
                  state_ff     <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (proc_valid_ff && (proc_idx_ff == LAST_KEY)) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= bitmap_ff & LIVE_MASK;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> (state_ff == S_SCAN))
      else $error("key state written outside a scan");

   a_scan_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (rd_active_ff && (rd_idx_ff == '0) && !proc_valid_ff))
      else $error("scan did not start at the first key");

   a_no_read_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!rd_active_ff && !proc_valid_ff))
      else $error("key walk active while idle");

   a_dead_bits_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff & ~LIVE_MASK) == '0))
      else $error("pressed bit set for a key that does not exist");

   a_finish_after_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && $past(state_ff == S_SCAN) && !rd_active_ff
       && !proc_valid_ff) |-> 1'b0)
      else $error("scan stalled without reaching the last key");

endmodule
